// File: hw/rtl/square_circle_collision_test_top_macros.svh
// ---------------------------------------------------------------------------
// Square/circle collision test: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SQUARE_CIRCLE_COLLISION_TEST_TOP_MACROS_SVH
`define SQUARE_CIRCLE_COLLISION_TEST_TOP_MACROS_SVH

// same-cycle implication
`define SCCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scct: assertion failed");

// next-cycle implication
`define SCCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scct: assertion failed");

`endif

// File: hw/rtl/scct_pkg.sv
// ---------------------------------------------------------------------------
// Square/circle collision test: package
// Field widths, fixed-point constants and request/result types.
// ---------------------------------------------------------------------------
`default_nettype none

package scct_pkg;

  localparam int FRAC_BITS = 12;
  localparam int POS_W     = 24;
  localparam int HALF_W    = 23;
  localparam int GRID_W    = 11;
  localparam int MARGIN_W  = 12;
  localparam int CFG_W     = (GRID_W > MARGIN_W) ? GRID_W : MARGIN_W;
  localparam int G_W       = GRID_W + FRAC_BITS;
  localparam int EDGE_W    = ((G_W > POS_W) ? G_W : POS_W) + 3;
  localparam int BND_W     = POS_W + 1;
  localparam int D_W       = POS_W + 2;
  localparam int RR_W      = HALF_W + 1;
  localparam int SQ_W      = 2 * D_W;
  localparam int SUM_W     = SQ_W + 1;

  localparam logic CFG_GRID_BOUNDARY = 1'b0;
  localparam logic CFG_EDGE_MARGIN   = 1'b1;

  localparam logic [GRID_W-1:0]   GRID_RESET   = GRID_W'(8);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(4);

  typedef struct packed {
    logic                     a_is_circle;
    logic signed [POS_W-1:0]  a_x;
    logic signed [POS_W-1:0]  a_y;
    logic [HALF_W-1:0]        a_half;
    logic                     b_is_circle;
    logic signed [POS_W-1:0]  b_x;
    logic signed [POS_W-1:0]  b_y;
    logic [HALF_W-1:0]        b_half;
    logic                     same_piece;
  } req_t;

  typedef struct packed {
    logic collide;
    logic hit_top;
    logic hit_right;
    logic hit_left;
    logic hit_bottom;
  } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/square_circle_collision_test_top.sv
// ---------------------------------------------------------------------------
// Square/circle collision test: top level
// Pairwise overlap test of two pieces with board-edge flags for the first.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid/req_ready, results leave on
//   rsp/rsp_valid/rsp_ready; both sides are valid/ready handshakes.
//   grid_boundary (index 0) and edge_margin (index 1) are written through
//   cfg_we/cfg_index/cfg_data while the block is idle.
//   Four register stages: bounds and edge sums, clamp and compares,
//   squaring multipliers, sum and final compare into the output register.
//   One request per cycle is sustained while rsp_ready stays high.
//   Each stage holds its item while the next one is full, so a stalled
//   receiver fills the pipeline and then drops req_ready; empty stages
//   still take new requests.
//   Reset (rst, synchronous) clears all stage valid bits and loads the
//   registers with 8 and 4.
// ---------------------------------------------------------------------------
`default_nettype none

module square_circle_collision_test_top import scct_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire [CFG_W-1:0]     cfg_data,
  input  wire                 req_valid,
  output logic                req_ready,
  input  req_t                req,
  output logic                rsp_valid,
  input  wire                 rsp_ready,
  output rsp_t                rsp
);

  logic [GRID_W-1:0]   grid_boundary;
  logic [MARGIN_W-1:0] edge_margin;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_boundary <= GRID_RESET;
      edge_margin   <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_BOUNDARY: grid_boundary <= cfg_data[GRID_W-1:0];
        CFG_EDGE_MARGIN:   edge_margin   <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4       = !v4 || rsp_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign rsp_valid = v4;

  // stage 0 -> 1: piece roles, box bounds, edge sums
  logic signed [POS_W-1:0] sq_x, sq_y, ci_x, ci_y;
  logic [HALF_W-1:0]       sq_h, ci_h;
  logic signed [EDGE_W-1:0] g_s;

  always_comb begin
    if (req.a_is_circle) begin
      sq_x = req.b_x;  sq_y = req.b_y;  sq_h = req.b_half;
      ci_x = req.a_x;  ci_y = req.a_y;  ci_h = req.a_half;
    end else begin
      sq_x = req.a_x;  sq_y = req.a_y;  sq_h = req.a_half;
      ci_x = req.b_x;  ci_y = req.b_y;  ci_h = req.b_half;
    end
    g_s = $signed(EDGE_W'({grid_boundary, FRAC_BITS'(0)}));
  end

  logic                     s1_same, s1_cc, s1_ss;
  logic signed [BND_W-1:0]  s1_sq_lox, s1_sq_hix, s1_sq_loy, s1_sq_hiy;
  logic signed [BND_W-1:0]  s1_ci_lox, s1_ci_hix, s1_ci_loy, s1_ci_hiy;
  logic signed [POS_W-1:0]  s1_ci_x, s1_ci_y;
  logic [HALF_W-1:0]        s1_ci_h, s1_a_h;
  logic signed [BND_W-1:0]  s1_dcx, s1_dcy;
  logic signed [EDGE_W-1:0] s1_top, s1_right, s1_left, s1_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_same   <= req.same_piece;
      s1_cc     <= req.a_is_circle && req.b_is_circle;
      s1_ss     <= !req.a_is_circle && !req.b_is_circle;
      s1_sq_lox <= BND_W'(sq_x) - $signed({2'b00, sq_h});
      s1_sq_hix <= BND_W'(sq_x) + $signed({2'b00, sq_h});
      s1_sq_loy <= BND_W'(sq_y) - $signed({2'b00, sq_h});
      s1_sq_hiy <= BND_W'(sq_y) + $signed({2'b00, sq_h});
      s1_ci_lox <= BND_W'(ci_x) - $signed({2'b00, ci_h});
      s1_ci_hix <= BND_W'(ci_x) + $signed({2'b00, ci_h});
      s1_ci_loy <= BND_W'(ci_y) - $signed({2'b00, ci_h});
      s1_ci_hiy <= BND_W'(ci_y) + $signed({2'b00, ci_h});
      s1_ci_x   <= ci_x;
      s1_ci_y   <= ci_y;
      s1_ci_h   <= ci_h;
      s1_a_h    <= req.a_half;
      s1_dcx    <= BND_W'(req.a_x) - BND_W'(req.b_x);
      s1_dcy    <= BND_W'(req.a_y) - BND_W'(req.b_y);
      s1_top    <= g_s - $signed(EDGE_W'(req.a_half)) - EDGE_W'(req.a_y);
      s1_right  <= g_s - $signed(EDGE_W'(req.a_half)) - EDGE_W'(req.a_x);
      s1_left   <= $signed(EDGE_W'(req.a_half)) - EDGE_W'(req.a_x);
      s1_bottom <= $signed(EDGE_W'(req.a_half)) - EDGE_W'(req.a_y);
    end
  end

  // stage 1 -> 2: clamp distance, box overlap, edge compares
  logic signed [EDGE_W-1:0] eps_s;
  logic signed [D_W-1:0]    dx_n, dy_n;
  logic [RR_W-1:0]          rr_n;
  logic                     box_hit_n;

  always_comb begin
    eps_s = $signed(EDGE_W'(edge_margin));
    if (s1_cc) begin
      dx_n = D_W'(s1_dcx);
      dy_n = D_W'(s1_dcy);
      rr_n = {s1_a_h, 1'b0};
    end else begin
      if (BND_W'(s1_ci_x) < s1_sq_lox) begin
        dx_n = D_W'(s1_ci_x) - D_W'(s1_sq_lox);
      end else if (BND_W'(s1_ci_x) > s1_sq_hix) begin
        dx_n = D_W'(s1_ci_x) - D_W'(s1_sq_hix);
      end else begin
        dx_n = '0;
      end
      if (BND_W'(s1_ci_y) < s1_sq_loy) begin
        dy_n = D_W'(s1_ci_y) - D_W'(s1_sq_loy);
      end else if (BND_W'(s1_ci_y) > s1_sq_hiy) begin
        dy_n = D_W'(s1_ci_y) - D_W'(s1_sq_hiy);
      end else begin
        dy_n = '0;
      end
      rr_n = {1'b0, s1_ci_h};
    end
    box_hit_n = !(s1_sq_lox > s1_ci_hix || s1_sq_hix < s1_ci_lox ||
                  s1_sq_hiy < s1_ci_loy || s1_sq_loy > s1_ci_hiy);
  end

  logic                  s2_same, s2_cc, s2_ss, s2_box;
  logic signed [D_W-1:0] s2_dx, s2_dy;
  logic [RR_W-1:0]       s2_rr;
  logic [3:0]            s2_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_same <= s1_same;
      s2_cc   <= s1_cc;
      s2_ss   <= s1_ss;
      s2_box  <= box_hit_n;
      s2_dx   <= dx_n;
      s2_dy   <= dy_n;
      s2_rr   <= rr_n;
      s2_edge <= {s1_top <= eps_s, s1_right <= eps_s,
                  s1_left >= eps_s, s1_bottom >= eps_s};
    end
  end

  // stage 2 -> 3: squares
  logic                   s3_same, s3_cc, s3_ss, s3_box;
  logic signed [SQ_W-1:0] s3_dx2, s3_dy2;
  logic [2*RR_W-1:0]      s3_rr2;
  logic [3:0]             s3_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_same <= s2_same;
      s3_cc   <= s2_cc;
      s3_ss   <= s2_ss;
      s3_box  <= s2_box;
      s3_dx2  <= s2_dx * s2_dx;
      s3_dy2  <= s2_dy * s2_dy;
      s3_rr2  <= s2_rr * s2_rr;
      s3_edge <= s2_edge;
    end
  end

  // stage 3 -> 4: distance compare and result
  logic signed [SUM_W-1:0] dist2, rad2;
  logic                    hit_n;

  always_comb begin
    dist2 = SUM_W'(s3_dx2) + SUM_W'(s3_dy2);
    rad2  = $signed(SUM_W'(s3_rr2));
    if (s3_ss) begin
      hit_n = s3_box;
    end else if (s3_cc) begin
      hit_n = dist2 <= rad2;
    end else begin
      hit_n = dist2 < rad2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      rsp.collide    <= hit_n && !s3_same;
      rsp.hit_top    <= s3_edge[3];
      rsp.hit_right  <= s3_edge[2];
      rsp.hit_left   <= s3_edge[1];
      rsp.hit_bottom <= s3_edge[0];
    end
  end

`include "square_circle_collision_test_top_macros.svh"

  `SCCT_ASSERT_NOW(a_backpressure_full, !req_ready, v1 && v2 && v3 && v4 && !rsp_ready)
  `SCCT_ASSERT_NEXT(a_stage1_advance, v1 && en2, v2)
  `SCCT_ASSERT_NEXT(a_stage3_advance, v3 && en4, rsp_valid)

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Square/circle collision test: testbench
// Sends pairs of pieces through the request channel and checks every result
// against an in-bench predictor of the overlap test and the four board-edge
// flags. Runs directed corner cases first, then random pairs under several
// register settings with random idling on both sides, one long receiver
// hold-off that backs up the pipeline, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import scct_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int SETTLE_CYCLES  = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_GRID_BOUNDARY;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp;

  // register shadows
  logic [GRID_W-1:0]   grid_units = GRID_RESET;
  logic [MARGIN_W-1:0] margin_units = MARGIN_RESET;

  req_t pairs_to_send[$];
  rsp_t flags_due[$];

  bit req_fire;
  bit quiet;
  bit hold_arm;
  bit hold_used;
  int send_gap;
  int sink_stall;
  int sink_hold;
  int idle_cycles;
  int n_errors;
  int n_sent;
  int n_checked;
  int n_hits;
  int n_settings;

  square_circle_collision_test_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rsp_t collision_flags(req_t r);
    longint ax, ay, ah, bx, by, bh;
    longint sx, sy, sh, cx, cy, ch, px, py, dx, dy, rr, g, eps;
    rsp_t   o;
    ax = longint'($signed(r.a_x));
    ay = longint'($signed(r.a_y));
    ah = longint'(r.a_half);
    bx = longint'($signed(r.b_x));
    by = longint'($signed(r.b_y));
    bh = longint'(r.b_half);
    if (r.a_is_circle == r.b_is_circle && !r.a_is_circle) begin
      o.collide = !(ax - ah > bx + bh || ax + ah < bx - bh ||
                    ay + ah < by - bh || ay - ah > by + bh);
    end else if (r.a_is_circle == r.b_is_circle) begin
      dx = ax - bx;
      dy = ay - by;
      rr = 2 * ah;
      o.collide = (dx * dx + dy * dy <= rr * rr);
    end else begin
      // square is whichever piece is not the circle
      if (r.a_is_circle) begin
        sx = bx; sy = by; sh = bh; cx = ax; cy = ay; ch = ah;
      end else begin
        sx = ax; sy = ay; sh = ah; cx = bx; cy = by; ch = bh;
      end
      px = (cx < sx - sh) ? sx - sh : ((cx > sx + sh) ? sx + sh : cx);
      py = (cy < sy - sh) ? sy - sh : ((cy > sy + sh) ? sy + sh : cy);
      dx = cx - px;
      dy = cy - py;
      o.collide = (dx * dx + dy * dy < ch * ch);
    end
    if (r.same_piece) o.collide = 1'b0;
    g = longint'(grid_units) << FRAC_BITS;
    eps = longint'(margin_units);
    o.hit_top    = (g - ah - ay <= eps);
    o.hit_right  = (g - ah - ax <= eps);
    o.hit_left   = (ah - ax >= eps);
    o.hit_bottom = (ah - ay >= eps);
    return o;
  endfunction

  function automatic req_t pair(int ac, int ax, int ay, int ah,
                                int bc, int bx, int by, int bh, int same);
    req_t r;
    r.a_is_circle = ac[0];
    r.a_x = POS_W'(ax);
    r.a_y = POS_W'(ay);
    r.a_half = HALF_W'(ah);
    r.b_is_circle = bc[0];
    r.b_x = POS_W'(bx);
    r.b_y = POS_W'(by);
    r.b_half = HALF_W'(bh);
    r.same_piece = same[0];
    return r;
  endfunction

  // mostly near pairs and near-edge pieces, the rest full-range noise
  function automatic req_t random_pair();
    logic [159:0] raw;
    req_t         r;
    int           pick, span, ax, ay, g, d;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      span = 1 << $urandom_range(4, 18);
      ax = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      ay = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      r.a_x = POS_W'(ax);
      r.a_y = POS_W'(ay);
      r.a_half = HALF_W'($urandom_range(0, span));
      r.b_half = HALF_W'($urandom_range(0, span));
      r.b_x = POS_W'(ax + int'($urandom_range(0, 6 * span)) - 3 * span);
      r.b_y = POS_W'(ay + int'($urandom_range(0, 6 * span)) - 3 * span);
      r.same_piece = ($urandom_range(0, 7) == 0);
    end else if (pick < 7) begin
      g = int'(grid_units) << FRAC_BITS;
      r.a_half = HALF_W'($urandom_range(0, 1 << 12));
      d = int'(margin_units) + int'($urandom_range(0, 16)) - 8;
      r.a_y = POS_W'($urandom_range(0, 1) ? g - int'(r.a_half) - d : int'(r.a_half) - d);
      d = int'(margin_units) + int'($urandom_range(0, 16)) - 8;
      r.a_x = POS_W'($urandom_range(0, 1) ? g - int'(r.a_half) - d : int'(r.a_half) - d);
    end
    return r;
  endfunction

  task automatic send_random(int count);
    repeat (count) pairs_to_send.push_back(random_pair());
    n_sent += count;
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    if (idx == CFG_GRID_BOUNDARY) grid_units = val[GRID_W-1:0];
    else margin_units = val[MARGIN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_board(int unsigned grid, int unsigned margin);
    write_reg(CFG_GRID_BOUNDARY, grid);
    write_reg(CFG_EDGE_MARGIN, margin);
    n_settings++;
  endtask

  task automatic drain();
    while (pairs_to_send.size() != 0 || flags_due.size() != 0 || req_valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(string field, logic want, logic got);
    n_errors++;
    if (n_errors <= 20)
      $display("mismatch at %0t: %s expected %b got %b", $realtime, field, want, got);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 4) - 1;
        req_valid <= 1'b0;
      end else if (pairs_to_send.size() != 0) begin
        req <= pairs_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      sink_hold = HOLD_CYCLES;
    end
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      rsp_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 4) - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    rsp_t want;
    req_fire = !rst && req_valid && req_ready;
    if (req_fire) begin
      want = collision_flags(req);
      if (want.collide) n_hits++;
      flags_due.push_back(want);
    end
    if (!rst && rsp_valid && rsp_ready) begin
      if (flags_due.size() == 0) begin
        n_errors++;
        $display("unexpected result at %0t: %p", $realtime, rsp);
      end else begin
        want = flags_due.pop_front();
        n_checked++;
        if (rsp.collide !== want.collide)
          report_mismatch("collide", want.collide, rsp.collide);
        if (rsp.hit_top !== want.hit_top)
          report_mismatch("hit_top", want.hit_top, rsp.hit_top);
        if (rsp.hit_right !== want.hit_right)
          report_mismatch("hit_right", want.hit_right, rsp.hit_right);
        if (rsp.hit_left !== want.hit_left)
          report_mismatch("hit_left", want.hit_left, rsp.hit_left);
        if (rsp.hit_bottom !== want.hit_bottom)
          report_mismatch("hit_bottom", want.hit_bottom, rsp.hit_bottom);
      end
    end
  end

  // watchdog: no handshake while work is outstanding
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (pairs_to_send.size() == 0 && flags_due.size() == 0 && !req_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d results still due", flags_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    n_settings = 1;

    // corner cases at reset settings: board edge 8.0, margin 4
    pairs_to_send.push_back(pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 0, 0, 0, 100, 1));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 0, 200, 0, 100, 0));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 0, 201, 0, 100, 0));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 0, 0, -201, 100, 0));
    pairs_to_send.push_back(pair(1, 0, 0, 100, 1, 200, 0, 0, 0));
    pairs_to_send.push_back(pair(1, 0, 0, 100, 1, 201, 0, 0, 0));
    pairs_to_send.push_back(pair(1, 0, 0, 10, 1, 100, 0, 1000, 0));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 1, 150, 0, 50, 0));
    pairs_to_send.push_back(pair(0, 0, 0, 100, 1, 149, 0, 50, 0));
    pairs_to_send.push_back(pair(1, 130, 130, 43, 0, 0, 0, 100, 0));
    pairs_to_send.push_back(pair(1, 130, 130, 42, 0, 0, 0, 100, 0));
    pairs_to_send.push_back(pair(1, 10, 10, 0, 0, 0, 0, 100, 0));
    pairs_to_send.push_back(pair(0, -8388608, -8388608, 8388607,
                                 0, -8388608, -8388608, 8388607, 0));
    pairs_to_send.push_back(pair(1, 8388607, 8388607, 8388607,
                                 1, 8388607, 8388607, 8388607, 0));
    pairs_to_send.push_back(pair(1, -8388608, -8388608, 8388607,
                                 1, 8388607, 8388607, 8388607, 0));
    pairs_to_send.push_back(pair(0, 8388607, 8388607, 8388607,
                                 1, -8388608, -8388608, 8388607, 0));
    pairs_to_send.push_back(pair(0, 32763, 32764, 0, 0, 0, 0, 0, 0));
    pairs_to_send.push_back(pair(0, 32764, 32763, 0, 0, 0, 0, 0, 0));
    pairs_to_send.push_back(pair(0, 0, 1, 4, 0, 0, 0, 0, 0));
    pairs_to_send.push_back(pair(0, 1, 0, 4, 0, 0, 0, 0, 0));
    n_sent = pairs_to_send.size();
    send_random(80);
    drain();

    // zero board and margin, with a long receiver hold-off
    set_board(0, 0);
    hold_arm = 1'b1;
    send_random(100);
    drain();

    set_board(2047, 4095);
    send_random(100);
    drain();

    set_board($urandom_range(0, 2047), $urandom_range(0, 4095));
    send_random(80);
    drain();

    // full rate to the end
    set_board($urandom_range(1, 64), $urandom_range(0, 64));
    quiet = 1'b1;
    send_random(40);
    drain();

    $display("sent %0d requests under %0d board settings, %0d results checked",
             n_sent, n_settings, n_checked);
    $display("%0d predicted collisions, %0d mismatches", n_hits, n_errors);
    if (n_errors == 0 && flags_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
